// ===== rtl/journal_record_checker_assert.svh =====
// Assertion macros for the journal record checker.
// The macros expect i_clk and an active-low i_rst_n in the including module.
`ifndef JOURNAL_RECORD_CHECKER_ASSERT_SVH
`define JOURNAL_RECORD_CHECKER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define JRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define JRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/jrc_pkg.sv =====
// Shared constants, result type and CRC32C byte update for the journal record checker.
// Used by jrc_parser and journal_record_checker; depends on nothing.
package jrc_pkg;

    localparam int unsigned POS_W     = 33;
    localparam int unsigned SEQ_W     = 64;
    localparam int unsigned LEN_W     = 32;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W     = 64;

    localparam logic [POS_W-1:0] HEADER_BYTES   = 33'd12;
    localparam logic [POS_W-1:0] SEQUENCE_END   = 33'd20;
    localparam logic [POS_W-1:0] MAGIC_END      = 33'd8;
    localparam logic [LEN_W-1:0] SEQUENCE_BYTES = 32'd8;

    localparam logic [31:0] RECORD_MAGIC = 32'h314A_4346;
    localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd1048576;
    localparam logic [SEQ_W-1:0] SNAPSHOT_RESET = 64'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_SNAPSHOT_SEQ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN      = 1'b1;

    localparam logic [2:0] V_ACCEPTED = 3'd0;
    localparam logic [2:0] V_SKIPPED  = 3'd1;
    localparam logic [2:0] V_MAGIC    = 3'd2;
    localparam logic [2:0] V_TOO_LONG = 3'd3;
    localparam logic [2:0] V_CHECKSUM = 3'd4;
    localparam logic [2:0] V_SHORT    = 3'd5;
    localparam logic [2:0] V_TORN     = 3'd6;

    typedef struct packed {
        logic             is_event;
        logic             done;
        logic [2:0]       verdict;
        logic [SEQ_W-1:0] record_seq;
        logic [POS_W-1:0] torn;
        logic             failed;
    } t_result;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/jrc_parser.sv =====
// Record parser state and its combinational next-state and verdict logic.
// Depends on jrc_pkg for constants, the result struct and the CRC32C update.
module jrc_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [7:0]                i_byte,
    input  logic                      i_eos,
    input  logic [jrc_pkg::SEQ_W-1:0] i_snapshot_seq,
    input  logic [jrc_pkg::LEN_W-1:0] i_max_len,
    output jrc_pkg::t_result          o_result
);
    import jrc_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [63:0]      r_hdr, n_hdr;
    logic [31:0]      r_exp_crc, n_exp_crc;
    logic [LEN_W-1:0] r_len, n_len;
    logic [31:0]      r_crc, n_crc;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic             r_err, n_err;

    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] rec_end;
    logic [POS_W-1:0] off;
    logic             finish;
    t_result          res;

    assign pos_next = r_pos + 33'd1;
    assign rec_end  = {1'b0, r_len} + HEADER_BYTES;
    assign off      = r_pos - HEADER_BYTES;

    always_comb begin
        n_pos     = r_pos;
        n_hdr     = r_hdr;
        n_exp_crc = r_exp_crc;
        n_len     = r_len;
        n_crc     = r_crc;
        n_seq     = r_seq;
        n_err     = r_err;
        finish    = 1'b0;
        res       = '0;
        if (!r_err) begin
            if (r_pos < HEADER_BYTES) begin
                if (r_pos < MAGIC_END) begin
                    n_hdr[{r_pos[2:0], 3'b000} +: 8] = i_byte;
                end else begin
                    n_exp_crc[{r_pos[1:0], 3'b000} +: 8] = i_byte;
                end
                if (pos_next == HEADER_BYTES) begin
                    n_len = n_hdr[63:32];
                    if (n_hdr[31:0] != RECORD_MAGIC) begin
                        res.done    = 1'b1;
                        res.verdict = V_MAGIC;
                        n_err       = 1'b1;
                    end else if (n_len > i_max_len) begin
                        res.done    = 1'b1;
                        res.verdict = V_TOO_LONG;
                        n_err       = 1'b1;
                    end else if (n_len == '0) begin
                        finish = 1'b1;
                    end
                end
            end else begin
                n_crc = crc32c_byte(r_crc, i_byte);
                if (r_pos < SEQUENCE_END) begin
                    n_seq[{off[2:0], 3'b000} +: 8] = i_byte;
                end else begin
                    res.is_event = 1'b1;
                end
                if (pos_next == rec_end) begin
                    finish = 1'b1;
                end
            end

            if (finish) begin
                res.done = 1'b1;
                if (~n_crc != n_exp_crc) begin
                    res.verdict = V_CHECKSUM;
                    n_err       = 1'b1;
                end else if (n_len < SEQUENCE_BYTES) begin
                    res.verdict = V_SHORT;
                    n_err       = 1'b1;
                end else begin
                    res.record_seq = n_seq;
                    res.verdict    = (n_seq <= i_snapshot_seq) ? V_SKIPPED : V_ACCEPTED;
                end
            end

            if (res.done) begin
                n_pos     = '0;
                n_hdr     = '0;
                n_exp_crc = '0;
                n_len     = '0;
                n_crc     = CRC_INIT;
                n_seq     = '0;
            end else begin
                n_pos = pos_next;
                if (i_eos) begin
                    res.done    = 1'b1;
                    res.verdict = V_TORN;
                    res.torn    = pos_next;
                end
            end
        end
        res.failed = n_err;

        if (i_eos) begin
            n_pos     = '0;
            n_hdr     = '0;
            n_exp_crc = '0;
            n_len     = '0;
            n_crc     = CRC_INIT;
            n_seq     = '0;
            n_err     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_hdr     <= '0;
            r_exp_crc <= '0;
            r_len     <= '0;
            r_crc     <= CRC_INIT;
            r_seq     <= '0;
            r_err     <= 1'b0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_hdr     <= n_hdr;
            r_exp_crc <= n_exp_crc;
            r_len     <= n_len;
            r_crc     <= n_crc;
            r_seq     <= n_seq;
            r_err     <= n_err;
        end
    end

    assign o_result = res;

endmodule

// ===== rtl/journal_record_checker.sv =====
// Top level of the journal record checker: configuration, handshake and result register.
// Depends on jrc_pkg, jrc_parser and journal_record_checker_assert.svh.
//
//   port group     direction  beat
//   input bytes    in         i_valid / o_stall, one journal byte
//   results        out        o_valid / i_stall, one result per byte
//   configuration  in         i_cfg_we, two registers, no read-back
//
// The parser state and the CRC32C byte update sit between the input handshake and the
// result register, so a byte can enter every cycle unless a full result register is
// stalled. The result is registered and shows in the cycle after the byte is taken.
// Reset is synchronous and clears the parser and sets both registers to defaults.
// A byte is taken while the result register is empty, or while its beat leaves.
module journal_record_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_stream,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_out_byte,
    output logic                          o_is_event_byte,
    output logic                          o_record_done,
    output logic [2:0]                    o_verdict,
    output logic [63:0]                   o_record_sequence,
    output logic [32:0]                   o_torn_bytes,
    output logic                          o_failed,
    input  logic                          i_cfg_we,
    input  logic [jrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [jrc_pkg::CFG_W-1:0]     i_cfg_data
);
    import jrc_pkg::*;

    `include "journal_record_checker_assert.svh"

    logic [SEQ_W-1:0] r_snapshot_seq;
    logic [LEN_W-1:0] r_max_len;
    logic             r_valid, n_valid;
    logic [7:0]       r_byte;
    t_result          r_result;
    t_result          step_result;
    logic             accept;

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign n_valid = accept || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snapshot_seq <= SNAPSHOT_RESET;
            r_max_len      <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SNAPSHOT_SEQ: r_snapshot_seq <= i_cfg_data;
                CFG_MAX_LEN:      r_max_len      <= i_cfg_data[LEN_W-1:0];
                default:          r_max_len      <= r_max_len;
            endcase
        end
    end

    jrc_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (accept),
        .i_byte         (i_data_byte),
        .i_eos          (i_end_of_stream),
        .i_snapshot_seq (r_snapshot_seq),
        .i_max_len      (r_max_len),
        .o_result       (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte   <= i_data_byte;
            r_result <= step_result;
        end
    end

    assign o_valid           = r_valid;
    assign o_out_byte        = r_byte;
    assign o_is_event_byte   = r_result.is_event;
    assign o_record_done     = r_result.done;
    assign o_verdict         = r_result.verdict;
    assign o_record_sequence = r_result.record_seq;
    assign o_torn_bytes      = r_result.torn;
    assign o_failed          = r_result.failed;

    `JRC_ASSERT_SAME(a_stall_only_when_full, o_stall, r_valid,
        "input stalled while the result register is empty")
    `JRC_ASSERT_SAME(a_idle_fields_zero, r_valid && !r_result.done,
        r_result.verdict == V_ACCEPTED && r_result.record_seq == '0 && r_result.torn == '0,
        "verdict fields set on a beat without record_done")
    `JRC_ASSERT_SAME(a_torn_count_only_on_torn, r_valid && r_result.verdict != V_TORN,
        r_result.torn == '0, "torn byte count set without a torn tail verdict")
    `JRC_ASSERT_SAME(a_event_not_failed, r_valid && r_result.is_event && !r_result.done,
        !r_result.failed, "event byte forwarded while the error latch is set")
    `JRC_ASSERT_NEXT(a_held_when_stalled, r_valid && i_stall, r_valid,
        "result beat lost while the output was stalled")

endmodule

// ===== dv/journal_record_checker_test.sv =====
// Self-checking testbench for journal_record_checker: framed journal streams, config phases.
// Depends on jrc_pkg and the journal_record_checker RTL; needs no files or arguments.
// Byte beats are driven from a queue, and each result beat is checked against a local predictor.
`timescale 1ns / 100ps

module journal_record_checker_test;
    import jrc_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASES      = 7;
    localparam logic [32:0] HDR_LEN     = 33'd12;
    localparam logic [32:0] SEQ_LEN     = 33'd8;
    localparam logic [31:0] CASTAGNOLI  = 32'h82F6_3B78;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_journal_beat;

    typedef struct packed {
        logic [7:0]  data;
        logic        is_event;
        logic        done;
        logic [2:0]  verdict;
        logic [63:0] seq_num;
        logic [32:0] torn;
        logic        failed;
    } t_byte_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_data_byte = 8'd0;
    logic                 i_end_of_stream = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [7:0]           o_out_byte;
    logic                 o_is_event_byte;
    logic                 o_record_done;
    logic [2:0]           o_verdict;
    logic [63:0]          o_record_sequence;
    logic [32:0]          o_torn_bytes;
    logic                 o_failed;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    journal_record_checker dut (.*);

    t_journal_beat pending_beats[$];
    t_journal_beat stream_bytes[$];
    t_byte_result  expected_results[$];

    // Predictor state and its copy of the registers.
    logic [63:0] snap_seq;
    logic [31:0] len_limit;
    logic [32:0] rec_pos;
    logic [63:0] hdr_shift;
    logic [31:0] want_crc;
    logic [31:0] decl_len;
    logic [31:0] run_crc;
    logic [63:0] seq_acc;
    logic        err_latched;

    int n_queued = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int verdict_tally[7];
    bit quiet = 1'b0;
    bit long_hold = 1'b0;
    t_byte_result got_result;
    t_byte_result want_result;
    t_journal_beat next_beat;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] castagnoli_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb) begin
                c = c ^ CASTAGNOLI;
            end
        end
        return c;
    endfunction

    task automatic clear_record();
        rec_pos = '0;
        hdr_shift = '0;
        want_crc = '0;
        decl_len = '0;
        run_crc = 32'hFFFF_FFFF;
        seq_acc = '0;
    endtask

    task automatic predict_journal_byte(input logic [7:0] b, input logic eos);
        t_byte_result r;
        logic [32:0]  nxt;
        logic [32:0]  off;
        logic         fin;
        r = '0;
        r.data = b;
        fin = 1'b0;
        if (!err_latched) begin
            nxt = rec_pos + 33'd1;
            if (rec_pos < HDR_LEN) begin
                if (rec_pos < SEQ_LEN) begin
                    hdr_shift = hdr_shift | (64'(b) << (8 * rec_pos[2:0]));
                end else begin
                    want_crc = want_crc | (32'(b) << (8 * rec_pos[1:0]));
                end
                if (nxt == HDR_LEN) begin
                    decl_len = hdr_shift[63:32];
                    if (hdr_shift[31:0] != RECORD_MAGIC) begin
                        r.done = 1'b1;
                        r.verdict = V_MAGIC;
                        err_latched = 1'b1;
                    end else if (decl_len > len_limit) begin
                        r.done = 1'b1;
                        r.verdict = V_TOO_LONG;
                        err_latched = 1'b1;
                    end else if (decl_len == 32'd0) begin
                        fin = 1'b1;
                    end
                end
            end else begin
                off = rec_pos - HDR_LEN;
                run_crc = castagnoli_update(run_crc, b);
                if (off < SEQ_LEN) begin
                    seq_acc = seq_acc | (64'(b) << (8 * off[2:0]));
                end else begin
                    r.is_event = 1'b1;
                end
                if (nxt == HDR_LEN + {1'b0, decl_len}) begin
                    fin = 1'b1;
                end
            end
            if (fin) begin
                r.done = 1'b1;
                if (~run_crc != want_crc) begin
                    r.verdict = V_CHECKSUM;
                    err_latched = 1'b1;
                end else if (decl_len < 32'(SEQ_LEN)) begin
                    r.verdict = V_SHORT;
                    err_latched = 1'b1;
                end else begin
                    r.seq_num = seq_acc;
                    r.verdict = (seq_acc <= snap_seq) ? V_SKIPPED : V_ACCEPTED;
                end
            end
            if (r.done) begin
                clear_record();
            end else begin
                rec_pos = nxt;
                if (eos) begin
                    r.done = 1'b1;
                    r.verdict = V_TORN;
                    r.torn = nxt;
                end
            end
            if (r.done) begin
                verdict_tally[r.verdict]++;
            end
        end
        r.failed = err_latched;
        expected_results = {expected_results, r};
        if (eos) begin
            clear_record();
            err_latched = 1'b0;
        end
    endtask

    function automatic string show(input t_byte_result r);
        return $sformatf("byte %h ev %b done %b verdict %0d seq %h torn %h failed %b",
                         r.data, r.is_event, r.done, r.verdict, r.seq_num, r.torn, r.failed);
    endfunction

    task automatic log_mismatch(input bit orphan, input t_byte_result want, input t_byte_result got);
        n_errors++;
        if (n_errors <= 10) begin
            if (orphan) begin
                $display("result %0d with nothing expected: %s", n_checked, show(got));
            end else begin
                $display("result %0d mismatch: expected %s", n_checked, show(want));
                $display("    actual %s", show(got));
            end
        end
    endtask

    // Byte driver: predicts each accepted beat, then offers the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_journal_byte(i_data_byte, i_end_of_stream);
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() != 0 && !quiet && !long_hold &&
                             $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(1, 18) - 1;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    next_beat = pending_beats.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= next_beat.data;
                    i_end_of_stream <= next_beat.eos;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got_result.data = o_out_byte;
                got_result.is_event = o_is_event_byte;
                got_result.done = o_record_done;
                got_result.verdict = o_verdict;
                got_result.seq_num = o_record_sequence;
                got_result.torn = o_torn_bytes;
                got_result.failed = o_failed;
                if (expected_results.size() == 0) begin
                    log_mismatch(1'b1, '0, got_result);
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result !== want_result) begin
                        log_mismatch(1'b0, want_result, got_result);
                    end
                end
                n_checked++;
            end
            if (long_hold) begin
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                recv_gap = $urandom_range(1, 18) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // A long receiver hold-off while bytes keep coming, to back up the input.
    initial begin
        wait (n_accepted >= 400);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", n_cycles,
                     expected_results.size());
            $display("journal_record_checker_test: errors");
            $finish;
        end
    end

    function automatic logic [63:0] pick_sequence();
        case ($urandom_range(0, 5))
            0: return snap_seq;
            1: return snap_seq + 64'd1;
            2: return snap_seq - 64'd1;
            3: return 64'd0;
            4: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_beat(input logic [7:0] d, input logic e);
        t_journal_beat beat;
        beat.data = d;
        beat.eos = e;
        stream_bytes = {stream_bytes, beat};
    endtask

    task automatic add_record(input logic [31:0] magic, input logic [31:0] len,
                              input logic [63:0] seq, input bit good_crc, input int body_len);
        logic [7:0]  body[$];
        logic [7:0]  nb;
        logic [31:0] crc;
        logic [95:0] hdr;
        crc = 32'hFFFF_FFFF;
        for (int i = 0; i < body_len; i++) begin
            nb = i < 8 ? seq[8 * (i % 8) +: 8] : 8'($urandom);
            body = {body, nb};
            crc = castagnoli_update(crc, body[i]);
        end
        crc = ~crc;
        if (!good_crc) begin
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        end
        hdr = {crc, len, magic};
        for (int i = 0; i < 12; i++) begin
            queue_beat(hdr[8 * i +: 8], 1'b0);
        end
        foreach (body[i]) begin
            queue_beat(body[i], 1'b0);
        end
    endtask

    task automatic close_stream();
        t_journal_beat tail;
        tail = stream_bytes.pop_back();
        tail.eos = 1'b1;
        stream_bytes = {stream_bytes, tail};
    endtask

    task automatic add_stream();
        int          n_rec;
        int          kind;
        int          len;
        bit          ended;
        bit          torn_end;
        logic [31:0] long_len;
        logic [63:0] seq;
        n_rec = $urandom_range(1, 5);
        ended = 1'b0;
        torn_end = 1'b0;
        for (int r = 0; r < n_rec && !ended; r++) begin
            kind = $urandom_range(0, 99);
            len = ($urandom_range(0, 7) == 0) ? 8 : $urandom_range(9, 40);
            seq = pick_sequence();
            if (kind < 70) begin
                add_record(RECORD_MAGIC, len, seq, 1'b1, len);
            end else if (kind < 76) begin
                add_record(RECORD_MAGIC, len, seq, 1'b0, len);
                ended = 1'b1;
            end else if (kind < 80) begin
                len = $urandom_range(0, 7);
                add_record(RECORD_MAGIC, len, seq, 1'b1, len);
                ended = 1'b1;
            end else if (kind < 84) begin
                add_record($urandom_range(0, 1) ? $urandom : RECORD_MAGIC ^ (32'd1 <<
                           $urandom_range(0, 31)), $urandom, seq, 1'b1, 0);
                ended = 1'b1;
            end else if (kind < 88) begin
                long_len = (len_limit > 32'hFFFF_FFF0) ? 32'hFFFF_FFFF :
                           len_limit + 32'($urandom_range(1, 3));
                add_record(RECORD_MAGIC, long_len, seq, 1'b1, 0);
                ended = 1'b1;
            end else if (kind < 94) begin
                if ($urandom_range(0, 1)) begin
                    add_record(RECORD_MAGIC, len, seq, 1'b1, 0);
                    repeat ($urandom_range(1, 11)) void'(stream_bytes.pop_back());
                end else if ($urandom_range(0, 1)) begin
                    add_record(RECORD_MAGIC, len, seq, 1'b1, $urandom_range(0, len - 1));
                end else begin
                    add_record(RECORD_MAGIC, $urandom, seq, 1'b1, $urandom_range(0, 20));
                end
                ended = 1'b1;
                torn_end = 1'b1;
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    queue_beat(8'($urandom), 1'b0);
                end
            end
        end
        if (ended && !torn_end) begin
            repeat ($urandom_range(0, 5)) begin
                queue_beat(8'($urandom), 1'b0);
            end
        end
        close_stream();
    endtask

    task automatic release_stream_bytes();
        @(negedge i_clk);
        pending_beats = {pending_beats, stream_bytes};
        n_queued += stream_bytes.size();
        stream_bytes = {};
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (n_accepted != n_queued || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SNAPSHOT_SEQ) begin
            snap_seq = value;
        end else begin
            len_limit = value[31:0];
        end
    endtask

    initial begin
        logic [63:0] snap_plan[PHASES];
        logic [31:0] limit_plan[PHASES];
        snap_plan  = '{64'd0, '1, {$urandom, $urandom}, 64'd1000, 64'h8000_0000_0000_0000,
                       {$urandom, $urandom}, 64'd0};
        limit_plan = '{MAX_LEN_RESET, 32'hFFFF_FFFF, 32'd0, 32'd20, 32'd8,
                       $urandom_range(64, 32'h7FFF_FFFF), 32'd40};
        foreach (verdict_tally[i]) begin
            verdict_tally[i] = 0;
        end
        snap_seq = SNAPSHOT_RESET;
        len_limit = MAX_LEN_RESET;
        clear_record();
        err_latched = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty record whose CRC matches, a one-byte torn stream, and an all-ones header.
        add_record(RECORD_MAGIC, 32'd0, 64'd0, 1'b1, 0);
        close_stream();
        queue_beat(8'h00, 1'b1);
        repeat (12) queue_beat(8'hFF, 1'b0);
        close_stream();
        release_stream_bytes();
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            quiet = (p == PHASES - 1);
            write_reg(CFG_SNAPSHOT_SEQ, snap_plan[p]);
            write_reg(CFG_MAX_LEN, {32'd0, limit_plan[p]});
            while (stream_bytes.size() < 215) begin
                add_stream();
            end
            release_stream_bytes();
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        n_errors += expected_results.size();
        $display("run covered %0d byte beats over %0d register settings, %0d mismatches",
                 n_checked, PHASES, n_errors);
        $display("verdicts: accepted %0d skipped %0d magic %0d too long %0d crc %0d short %0d torn %0d",
                 verdict_tally[V_ACCEPTED], verdict_tally[V_SKIPPED], verdict_tally[V_MAGIC],
                 verdict_tally[V_TOO_LONG], verdict_tally[V_CHECKSUM], verdict_tally[V_SHORT],
                 verdict_tally[V_TORN]);
        if (n_errors == 0) begin
            $display("journal_record_checker_test: clean");
        end else begin
            $display("journal_record_checker_test: errors");
        end
        $finish;
    end

endmodule

// ===== journal_record_checker.f =====
+incdir+rtl
rtl/jrc_pkg.sv
rtl/jrc_parser.sv
rtl/journal_record_checker.sv
dv/journal_record_checker_test.sv
